>>> rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

  localparam int unsigned NumFramesDef = 16;

  localparam int unsigned PageW    = 16;
  localparam int unsigned FreqW    = 16;
  localparam int unsigned StampW   = 32;
  localparam int unsigned FaultW   = 32;
  localparam int unsigned CfgW     = 5;
  localparam int unsigned IdxOutW  = 4;

  localparam logic [CfgW-1:0]   CfgReset = CfgW'(16);
  localparam logic [FreqW-1:0]  FreqMax  = '1;
  localparam logic [StampW-1:0] StampMax = '1;
  localparam logic [FaultW-1:0] FaultMax = '1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWait,
    StDone
  } state_e;

  // One frame table entry as held in the table memory.
  typedef struct packed {
    logic [PageW-1:0]  page;
    logic [FreqW-1:0]  freq;
    logic [StampW-1:0] stamp;
  } entry_t;

  // Per-cycle control of the scan unit.
  typedef struct packed {
    logic clear;   // start of a new lookup
    logic vld;     // read data belongs to an active frame
    logic first;   // entry is frame zero
    logic filled;  // entry holds a resident page
  } scan_ctl_t;

  // Outcome of a scan: matching entry on a hit, otherwise the victim.
  typedef struct packed {
    logic   hit;
    entry_t entry;
  } sel_t;

endpackage

`default_nettype wire

>>> rtl/lfu_in_if.sv
// ----------------------------------------------------------------------------
// lfu_in_if
// Page reference channel: one page number per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfu_in_if
  import lfu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PageW-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

`default_nettype wire

>>> rtl/lfu_out_if.sv
// ----------------------------------------------------------------------------
// lfu_out_if
// Result channel: lookup outcome of one page reference per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfu_out_if
  import lfu_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [IdxOutW-1:0] frame_index;
  logic               evicted_valid;
  logic [PageW-1:0]   evicted_page;
  logic [FaultW-1:0]  fault_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

`default_nettype wire

>>> rtl/lfu_cfg_if.sv
// ----------------------------------------------------------------------------
// lfu_cfg_if
// Configuration write channel for the active frame count.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfu_cfg_if
  import lfu_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

>>> rtl/lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// lfu_page_replacement
// LFU page replacement over a frame table kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// Sequence: an accepted word reads the n active frames in StScan, n being
//   the active frame count, settles the last compare in StWait, then in
//   StDone writes back and loads the result, holding there on output stall.
//   A new word waits for StIdle; the single read port reads one frame per cycle.
// Reset: counters and fault count clear, load stamp resets to one; the table
//   RAM needs no clearing pass, residency follows from the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_page_replacement
  import lfu_pkg::*;
#(
  parameter int unsigned NumFrames = NumFramesDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lfu_cfg_if.sink    cfg_i,
  lfu_in_if.sink     req_i,
  lfu_out_if.source  rsp_o
);

  localparam int unsigned IdxW = (NumFrames > 1) ? $clog2(NumFrames) : 1;
  localparam int unsigned CntW = $clog2(NumFrames + 1);

  // Control state
  state_e            state_q, state_d;
  logic [CfgW-1:0]   frames_q;
  logic [CntW-1:0]   filled_q, filled_d;
  logic [StampW-1:0] stamp_q, stamp_d;
  logic [FaultW-1:0] faults_q, faults_d;
  logic [IdxW-1:0]   addr_q, addr_d;
  logic              cmp_vld_q;
  logic [IdxW-1:0]   cmp_idx_q;
  logic              out_vld_q, out_vld_d;

  // Per-word payload
  logic [PageW-1:0]   page_q, page_d;
  logic [CntW-1:0]    n_q, n_d;
  logic               out_hit_q, out_hit_d;
  logic [IdxOutW-1:0] out_idx_q, out_idx_d;
  logic               out_ev_q, out_ev_d;
  logic [PageW-1:0]   out_evp_q, out_evp_d;
  logic [FaultW-1:0]  out_flt_q, out_flt_d;

  logic [CntW-1:0] active_n;
  logic            req_fire;
  logic            done_fire;
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata, ram_rdata;
  scan_ctl_t       scan_ctl;
  sel_t            sel;
  logic [IdxW-1:0] sel_idx;
  logic [IdxW-1:0] slot;

  // Clamp the configured count into 1..NumFrames
  always_comb begin
    if (32'(frames_q) > NumFrames) begin
      active_n = CntW'(NumFrames);
    end else if (frames_q == '0) begin
      active_n = CntW'(1);
    end else begin
      active_n = CntW'(frames_q);
    end
  end

  // User must write configuration only while idle; not enforced, always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= CfgReset;
    end else if (cfg_i.valid) begin
      frames_q <= cfg_i.frames_in_use;
    end
  end

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;

  // Scan control: data read in the previous cycle is tagged with its index.
  // Frames below the fill count are exactly the resident ones.
  assign scan_ctl.clear  = req_fire;
  assign scan_ctl.vld    = cmp_vld_q;
  assign scan_ctl.first  = (cmp_idx_q == '0);
  assign scan_ctl.filled = (CntW'(cmp_idx_q) < filled_q);

  // Sequencer: issue reads, let the last compare settle, then write back.
  // The write lands before the next lookup starts, so no forwarding is needed.
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    page_d    = page_q;
    n_d       = n_q;
    ram_re    = 1'b0;
    done_fire = 1'b0;
    case (state_q)
      StIdle: begin
        if (req_fire) begin
          page_d  = req_i.page_number;
          n_d     = active_n;
          addr_d  = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        ram_re = 1'b1;
        if (CntW'(addr_q) == n_q - CntW'(1)) begin
          state_d = StWait;
        end else begin
          addr_d = addr_q + IdxW'(1);
        end
      end
      StWait: begin
        state_d = StDone;
      end
      StDone: begin
        // hold until the output register is free
        if (!out_vld_q || rsp_o.ready) begin
          done_fire = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Write-back and result
  always_comb begin
    filled_d  = filled_q;
    stamp_d   = stamp_q;
    faults_d  = faults_q;
    ram_we    = 1'b0;
    slot      = sel_idx;
    ram_wdata = sel.entry;
    out_hit_d = out_hit_q;
    out_idx_d = out_idx_q;
    out_ev_d  = out_ev_q;
    out_evp_d = out_evp_q;
    out_flt_d = out_flt_q;
    out_vld_d = out_vld_q && !rsp_o.ready;

    if (sel.hit) begin
      // bump the frequency, keep page and load stamp
      if (sel.entry.freq != FreqMax) begin
        ram_wdata.freq = sel.entry.freq + FreqW'(1);
      end
    end else begin
      // fill the next empty frame, else evict the selected victim
      if (filled_q < n_q) begin
        slot = filled_q[IdxW-1:0];
      end
      ram_wdata.page  = page_q;
      ram_wdata.freq  = FreqW'(1);
      ram_wdata.stamp = stamp_q;
    end

    if (done_fire) begin
      ram_we    = 1'b1;
      out_vld_d = 1'b1;
      out_hit_d = sel.hit;
      out_idx_d = IdxOutW'(slot);
      out_ev_d  = 1'b0;
      out_evp_d = '0;
      out_flt_d = faults_q;
      if (!sel.hit) begin
        if (filled_q < n_q) begin
          filled_d = filled_q + CntW'(1);
        end else begin
          out_ev_d  = 1'b1;
          out_evp_d = sel.entry.page;
        end
        if (stamp_q != StampMax) begin
          stamp_d = stamp_q + StampW'(1);
        end
        if (faults_q != FaultMax) begin
          faults_d = faults_q + FaultW'(1);
        end
        out_flt_d = faults_d;
      end
    end
  end

  assign ram_waddr = slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      filled_q  <= '0;
      stamp_q   <= StampW'(1);
      faults_q  <= '0;
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      filled_q  <= filled_d;
      stamp_q   <= stamp_d;
      faults_q  <= faults_d;
      addr_q    <= addr_d;
      cmp_vld_q <= ram_re;
      cmp_idx_q <= addr_q;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q    <= page_d;
    n_q       <= n_d;
    out_hit_q <= out_hit_d;
    out_idx_q <= out_idx_d;
    out_ev_q  <= out_ev_d;
    out_evp_q <= out_evp_d;
    out_flt_q <= out_flt_d;
  end

  lfu_ram #(
    .Width ($bits(entry_t)),
    .Depth (NumFrames)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  lfu_scan #(
    .NumFrames (NumFrames)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .idx_i     (cmp_idx_q),
    .page_i    (page_q),
    .rdata_i   (ram_rdata),
    .sel_o     (sel),
    .sel_idx_o (sel_idx)
  );

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.frame_index   = out_idx_q;
  assign rsp_o.evicted_valid = out_ev_q;
  assign rsp_o.evicted_page  = out_evp_q;
  assign rsp_o.fault_count   = out_flt_q;

endmodule

`default_nettype wire

>>> rtl/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/lfu_scan.sv
// ----------------------------------------------------------------------------
// lfu_scan
// Walks the entries read from the frame table: finds the first hit and
// otherwise keeps the least frequent, earliest loaded frame as victim.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_scan
  import lfu_pkg::*;
#(
  parameter int unsigned NumFrames = NumFramesDef,
  localparam int unsigned IdxW = (NumFrames > 1) ? $clog2(NumFrames) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire scan_ctl_t       ctl_i,
  input  wire logic [IdxW-1:0] idx_i,
  input  wire logic [PageW-1:0] page_i,
  input  wire entry_t          rdata_i,
  output sel_t                 sel_o,
  output logic      [IdxW-1:0] sel_idx_o
);

  logic            hit_q, hit_d;
  entry_t          entry_q, entry_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            match;
  logic            better;

  always_comb begin
    match  = ctl_i.filled && (rdata_i.page == page_i);
    better = (rdata_i.freq < entry_q.freq) ||
             ((rdata_i.freq == entry_q.freq) && (rdata_i.stamp < entry_q.stamp));
    hit_d   = hit_q;
    entry_d = entry_q;
    idx_d   = idx_q;
    if (ctl_i.clear) begin
      hit_d = 1'b0;
    end else if (ctl_i.vld && !hit_q) begin
      // a hit freezes the selection; strict compare keeps the lowest index on ties
      if (match || ctl_i.first || better) begin
        hit_d   = match;
        entry_d = rdata_i;
        idx_d   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    idx_q   <= idx_d;
  end

  assign sel_o.hit   = hit_q;
  assign sel_o.entry = entry_q;
  assign sel_idx_o   = idx_q;

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LFU page replacement block. A driver feeds page
// references from a queue. Each accepted word is run through a behavioral LFU
// frame table held here. A monitor compares every result word with the oldest
// prediction. Frame-count settings are changed between phases while the block
// is idle.
// ----------------------------------------------------------------------------
module tb
  import lfu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted outcome of one page reference, laid out like the result word.
  typedef struct packed {
    logic               hit;
    logic [IdxOutW-1:0] frame_index;
    logic               evicted_valid;
    logic [PageW-1:0]   evicted_page;
    logic [FaultW-1:0]  fault_count;
  } lookup_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lfu_cfg_if cfg_if ();
  lfu_in_if  req_if ();
  lfu_out_if rsp_if ();

  // Bench-side drive registers; initializers keep every input known from time zero.
  logic             cfg_valid = 1'b0;
  logic [CfgW-1:0]  cfg_value = CfgReset;
  logic             req_valid = 1'b0;
  logic [PageW-1:0] req_page  = '0;
  logic             rsp_ready = 1'b0;

  assign cfg_if.valid         = cfg_valid;
  assign cfg_if.frames_in_use = cfg_value;
  assign req_if.valid         = req_valid;
  assign req_if.page_number   = req_page;
  assign rsp_if.ready         = rsp_ready;

  lfu_page_replacement u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Behavioral frame table. Mirrors the block's state; all entries start at
  // zero, and page and stamp are only ever read for resident frames.
  // --------------------------------------------------------------------------
  bit [PageW-1:0]  frame_page     [NumFramesDef];
  bit              frame_resident [NumFramesDef];
  bit [FreqW-1:0]  frame_uses     [NumFramesDef];
  bit [StampW-1:0] frame_stamp    [NumFramesDef];
  bit [StampW-1:0] load_stamp_next = 1;
  int unsigned     frames_filled   = 0;
  bit [FaultW-1:0] fault_total     = '0;
  logic [CfgW-1:0] frames_cfg      = CfgReset;

  // Run one page reference through the table and return the result word the
  // block must produce for it.
  function automatic lookup_t replace_page(input logic [PageW-1:0] page);
    lookup_t     res;
    int unsigned active;
    int unsigned slot;
    int unsigned f;
    res  = '0;
    slot = 0;
    // A count of zero behaves as one; anything past the table size clamps.
    active = (frames_cfg == 0) ? 1 :
             ((frames_cfg > NumFramesDef) ? NumFramesDef : frames_cfg);

    // Lowest active frame holding the page wins; frames above the active
    // count keep their contents but are invisible here.
    for (f = 0; f < active; f++) begin
      if (!res.hit && frame_resident[f] && frame_page[f] == page) begin
        res.hit = 1'b1;
        slot    = f;
      end
    end

    if (res.hit) begin
      if (frame_uses[slot] != FreqMax) frame_uses[slot]++;
    end else begin
      if (frames_filled < active) begin
        // Empty frames fill in index order, also after the count grows.
        slot = frames_filled;
        frames_filled++;
      end else begin
        // Victim: fewest uses, then oldest load, then lowest index.
        for (f = 1; f < active; f++) begin
          if (frame_uses[f] < frame_uses[slot] ||
              (frame_uses[f] == frame_uses[slot] && frame_stamp[f] < frame_stamp[slot]))
            slot = f;
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = frame_page[slot];
      end
      frame_page[slot]     = page;
      frame_resident[slot] = 1'b1;
      frame_uses[slot]     = 1;
      frame_stamp[slot]    = load_stamp_next;
      if (load_stamp_next != StampMax) load_stamp_next++;
      if (fault_total != FaultMax) fault_total++;
    end

    res.frame_index = IdxOutW'(slot);
    res.fault_count = fault_total;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Traffic shaping and bookkeeping
  // --------------------------------------------------------------------------
  logic [PageW-1:0] page_refs[$];        // references waiting to be offered
  lookup_t          lookups_pending[$];  // predictions awaiting their result word
  int unsigned      words_queued   = 0;
  int unsigned      words_accepted = 0;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_idle_pct  = 0;
  int unsigned      mismatches     = 0;
  int unsigned      results_seen   = 0;
  int unsigned      hits_seen      = 0;
  int unsigned      evictions_seen = 0;
  int unsigned      cfg_writes     = 0;
  logic             rsp_hold       = 1'b0;
  logic             long_hold_go   = 1'b0;

  // Frame-count settings of the random phases: clamped, zero and odd sizes.
  logic [CfgW-1:0] phase_frames [12] = '{5'd16, 5'd1, 5'd3, 5'd8, 5'd31, 5'd0,
                                         5'd5, 5'd12, 5'd20, 5'd2, 5'd7, 5'd16};

  // --------------------------------------------------------------------------
  // Driver: offer the next reference, hold it until the block takes it, and
  // predict its outcome at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_if.ready) begin
        lookups_pending.push_back(replace_page(req_page));
        words_accepted++;
      end
      // Only move on once the current word is gone; a held word stays put.
      if (!req_valid || req_if.ready) begin
        if (page_refs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req_page  <= page_refs.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string field, input logic [FaultW-1:0] want,
                             input logic [FaultW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result word against the oldest prediction,
  // then randomly stall or drop ready for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lookup_t want;
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        results_seen++;
        if (rsp_if.hit === 1'b1) hits_seen++;
        if (rsp_if.evicted_valid === 1'b1) evictions_seen++;
        if (lookups_pending.size() == 0) begin
          mismatches++;
          $display("%0t ns: result word with no reference pending, expected none, got hit %0b frame %0d",
                   $time, rsp_if.hit, rsp_if.frame_index);
        end else begin
          want = lookups_pending.pop_front();
          check_field("hit", FaultW'(want.hit), FaultW'(rsp_if.hit));
          check_field("frame_index", FaultW'(want.frame_index), FaultW'(rsp_if.frame_index));
          check_field("evicted_valid", FaultW'(want.evicted_valid),
                      FaultW'(rsp_if.evicted_valid));
          check_field("evicted_page", FaultW'(want.evicted_page), FaultW'(rsp_if.evicted_page));
          check_field("fault_count", want.fault_count, rsp_if.fault_count);
        end
      end
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold off the result side for a long stretch once, so the block backs up
  // and has to stall its input while the driver keeps offering words.
  initial begin : long_hold
    wait (long_hold_go);
    @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_page(input logic [PageW-1:0] page);
    page_refs.push_back(page);
    words_queued++;
  endtask

  // Wait until every queued word went in and every result came back, then
  // let the block settle idle before the next step.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (words_accepted != words_queued || lookups_pending.size() != 0);
    repeat (NumFramesDef + 4) @(posedge clk_i);
  endtask

  // Write the active frame count; only called while the block is idle.
  task automatic write_frames(input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_value <= value;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_valid  <= 1'b0;
    frames_cfg  = value;
    cfg_writes++;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [PageW-1:0] pool[$];
    int unsigned      ph;
    int unsigned      k;
    int unsigned      eff;
    int unsigned      pool_size;
    int unsigned      hot_top;
    int unsigned      pick;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(38, 72);

    // Directed: two frames, fill, hit, evict the less used one.
    write_frames(2);
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    queue_page(16'h0000);
    queue_page(16'h1234);
    wait_drained();

    // Zero frames acts as one; frame 1 keeps its page but drops out of lookup.
    write_frames(0);
    queue_page(16'h1234);
    queue_page(16'h0000);
    wait_drained();

    // Oversized count clamps to the table; hit in the revived frame, fill the
    // empty frames in order, then evict.
    write_frames(31);
    queue_page(16'h1234);
    for (k = 1; k <= 14; k++) queue_page(PageW'(k));
    queue_page(16'hAAAA);
    queue_page(16'h5555);
    wait_drained();

    // Random phases: a working set of the active frames plus up to four more pages, with
    // a few hot pages so use counts spread out, plus stray references.
    for (ph = 0; ph < 12; ph++) begin
      if (ph == 4) set_idling(72, 38);
      if (ph == 8) set_idling(0, 0);
      write_frames(phase_frames[ph]);
      if (ph == 2) long_hold_go = 1'b1;

      eff = (phase_frames[ph] == 0) ? 1 :
            ((phase_frames[ph] > NumFramesDef) ? NumFramesDef : phase_frames[ph]);
      pool_size = eff + $urandom_range(4);
      hot_top   = (pool_size < 3) ? pool_size - 1 : 2;
      pool.delete();
      for (k = 0; k < pool_size; k++) pool.push_back(PageW'($urandom));

      for (k = 0; k < 96; k++) begin
        pick = $urandom_range(99);
        if (pick < 15)      queue_page(PageW'($urandom));
        else if (pick < 50) queue_page(pool[$urandom_range(hot_top)]);
        else                queue_page(pool[$urandom_range(pool_size - 1)]);
      end
      wait_drained();
    end

    $display("Summary: %0d page references checked, %0d hits, %0d evictions, %0d frame-count writes",
             results_seen, hits_seen, evictions_seen, cfg_writes);
    $display("Summary: frame counts 0 to 31 incl. clamping, three idling mixes, a long output stall");
    if (mismatches == 0 && lookups_pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
